@@ design/assert_macros.svh @@
// Assertion macros used by the datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ design/tsk_pkg.sv @@
// Shared constants, types and command/status structs of the topological sort core
package tsk_pkg;

	localparam int MAX_NODES = 64;
	localparam int MAX_EDGES = 4096;
	localparam int NODE_W    = 7;
	localparam int NODE_AW   = $clog2(MAX_NODES);
	localparam int EDGE_AW   = $clog2(MAX_EDGES);
	localparam int EDGE_CW   = EDGE_AW + 1;
	localparam int DEG_W     = EDGE_CW;
	localparam int QCNT_W    = NODE_AW + 1;

	typedef enum logic {
		OP_ADD = 1'b0,
		OP_RUN = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED,
		ST_SEED_DRAIN,
		ST_POP,
		ST_NODE,
		ST_LIST,
		ST_EDGE_RD,
		ST_EDGE_WAIT,
		ST_EDGE_DEG,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

	typedef struct packed {
		logic load_accept;
		logic run_start;
		logic seed_issue;
		logic pop_issue;
		logic node_latch;
		logic list_latch;
		logic edge_latch;
		logic deg_update;
		logic emit_begin;
		logic emit_next;
		logic clear_graph;
	} cmd_t;

	typedef struct packed {
		logic seed_done;
		logic queue_empty;
		logic list_nonempty;
		logic edge_end;
		logic emit_zero;
		logic emit_last;
	} stat_t;

endpackage

@@ design/tsk_ram.sv @@
// Generic simple dual-port RAM with registered read
module tsk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/tsk_ctrl.sv @@
// Controller state machine sequencing edge loads, the sort run and result emission
module tsk_ctrl
	import tsk_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  logic  opcode,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && opcode == OP_RUN) begin
					state_d = ST_SEED;
				end
			end
			ST_SEED: begin
				if (stat.seed_done) begin
					state_d = ST_SEED_DRAIN;
				end
			end
			ST_SEED_DRAIN: state_d = ST_POP;
			ST_POP: begin
				if (!stat.queue_empty) begin
					state_d = ST_NODE;
				end else if (stat.emit_zero) begin
					state_d = ST_EMIT_OUT;
				end else begin
					state_d = ST_EMIT_RD;
				end
			end
			ST_NODE: state_d = ST_LIST;
			ST_LIST: state_d = stat.list_nonempty ? ST_EDGE_RD : ST_POP;
			ST_EDGE_RD: state_d = ST_EDGE_WAIT;
			ST_EDGE_WAIT: state_d = ST_EDGE_DEG;
			ST_EDGE_DEG: state_d = stat.edge_end ? ST_POP : ST_EDGE_RD;
			ST_EMIT_RD: state_d = ST_EMIT_OUT;
			ST_EMIT_OUT: begin
				if (out_ready) begin
					state_d = stat.emit_last ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = (state_q == ST_IDLE);
		accept          = in_valid && in_ready;
		out_valid       = (state_q == ST_EMIT_OUT);
		cmd             = '0;
		cmd.load_accept = accept && (opcode == OP_ADD);
		cmd.run_start   = accept && (opcode == OP_RUN);
		case (state_q)
			ST_SEED: cmd.seed_issue = !stat.seed_done;
			ST_POP: begin
				cmd.pop_issue  = !stat.queue_empty;
				cmd.emit_begin = stat.queue_empty;
			end
			ST_NODE: cmd.node_latch = 1'b1;
			ST_LIST: cmd.list_latch = stat.list_nonempty;
			ST_EDGE_WAIT: cmd.edge_latch = 1'b1;
			ST_EDGE_DEG: cmd.deg_update = 1'b1;
			ST_EMIT_OUT: begin
				cmd.emit_next   = out_ready && !stat.emit_last;
				cmd.clear_graph = out_ready && stat.emit_last;
			end
			default: ;
		endcase
	end

endmodule

@@ design/tsk_datapath.sv @@
// Datapath: edge lists, in-degree store, ready queue and result fields
`include "assert_macros.svh"
module tsk_datapath
	import tsk_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [NODE_W-1:0] cfg_wr_data,
	input  logic [NODE_W-1:0] from_node,
	input  logic [NODE_W-1:0] to_node,
	input  cmd_t              cmd,
	output stat_t             stat,
	output logic [NODE_W-1:0] node,
	output logic              is_last,
	output logic              complete,
	output logic              overflow
);

	logic [NODE_W-1:0]    node_count_q;
	logic [NODE_W-1:0]    cnt;

	logic                 edge_vld_s2;
	logic [NODE_W-1:0]    from_s2;
	logic [NODE_W-1:0]    to_s2;
	logic [EDGE_CW-1:0]   edge_total_q;
	logic                 dropped_q;
	logic [MAX_NODES-1:0] deg_vld_q;
	logic [MAX_NODES-1:0] list_vld_q;

	logic                 fwd_deg_vld_q;
	logic [NODE_AW-1:0]   fwd_deg_addr_q;
	logic [DEG_W-1:0]     fwd_deg_data_q;
	logic                 fwd_tail_vld_q;
	logic [NODE_AW-1:0]   fwd_tail_addr_q;
	logic [EDGE_AW-1:0]   fwd_tail_data_q;

	logic [NODE_W-1:0]    seed_idx_q;
	logic                 chk_vld_s1;
	logic [NODE_AW-1:0]   chk_addr_s1;
	logic [QCNT_W-1:0]    qh_q;
	logic [QCNT_W-1:0]    qt_q;

	logic [NODE_W-1:0]    x_q;
	logic [NODE_W-1:0]    y_q;
	logic [EDGE_AW-1:0]   e_q;
	logic [EDGE_AW-1:0]   end_q;
	logic [EDGE_AW-1:0]   nxt_q;

	logic [NODE_AW-1:0]   src_idx;
	logic [NODE_AW-1:0]   dst_idx;
	logic [NODE_AW-1:0]   x_idx;
	logic [NODE_AW-1:0]   y_idx;
	logic [EDGE_AW-1:0]   edge_idx;
	logic                 edge_bad;
	logic                 edge_ok;
	logic [DEG_W-1:0]     deg_base;
	logic [EDGE_AW-1:0]   tail_cur;
	logic [DEG_W-1:0]     run_deg;
	logic [DEG_W-1:0]     run_deg_new;
	logic                 q_room;
	logic                 push_seed;
	logic                 push_run;
	logic                 push;
	logic [NODE_W-1:0]    push_node;

	logic                 deg_we;
	logic [NODE_AW-1:0]   deg_waddr;
	logic [DEG_W-1:0]     deg_wdata;
	logic [NODE_AW-1:0]   deg_raddr;
	logic [DEG_W-1:0]     deg_rdata;
	logic [NODE_AW-1:0]   tail_raddr;
	logic [NODE_AW-1:0]   head_raddr;
	logic [EDGE_AW-1:0]   head_rdata;
	logic [EDGE_AW-1:0]   tail_rdata;
	logic [NODE_W-1:0]    tgt_rdata;
	logic [EDGE_AW-1:0]   next_rdata;
	logic [NODE_W-1:0]    q_rdata;

	assign cnt = (node_count_q > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : node_count_q;

	assign src_idx  = NODE_AW'(from_s2 - 1'b1);
	assign dst_idx  = NODE_AW'(to_s2 - 1'b1);
	assign x_idx    = NODE_AW'(x_q - 1'b1);
	assign y_idx    = NODE_AW'(y_q - 1'b1);
	assign edge_idx = edge_total_q[EDGE_AW-1:0];

	assign edge_bad = (from_s2 == '0) || (from_s2 > cnt) || (to_s2 == '0) || (to_s2 > cnt)
		|| (edge_total_q == EDGE_CW'(MAX_EDGES));
	assign edge_ok  = edge_vld_s2 && !edge_bad;

	always_comb begin
		if (!deg_vld_q[dst_idx]) begin
			deg_base = '0;
		end else if (fwd_deg_vld_q && fwd_deg_addr_q == dst_idx) begin
			deg_base = fwd_deg_data_q;
		end else begin
			deg_base = deg_rdata;
		end
		if (fwd_tail_vld_q && fwd_tail_addr_q == src_idx) begin
			tail_cur = fwd_tail_data_q;
		end else begin
			tail_cur = tail_rdata;
		end
	end

	assign run_deg     = deg_vld_q[y_idx] ? deg_rdata : '0;
	assign run_deg_new = DEG_W'(run_deg - 1'b1);

	assign q_room    = (qt_q < QCNT_W'(MAX_NODES));
	assign push_seed = chk_vld_s1 && (!deg_vld_q[chk_addr_s1] || deg_rdata == '0) && q_room;
	assign push_run  = cmd.deg_update && (run_deg_new == '0) && (y_q <= cnt) && q_room;
	assign push      = push_seed || push_run;
	assign push_node = push_run ? y_q : NODE_W'(NODE_W'(chk_addr_s1) + 1'b1);

	always_comb begin
		if (cmd.load_accept) begin
			deg_raddr = NODE_AW'(to_node - 1'b1);
		end else if (cmd.edge_latch) begin
			deg_raddr = NODE_AW'(tgt_rdata - 1'b1);
		end else begin
			deg_raddr = NODE_AW'(seed_idx_q);
		end
		deg_we = edge_ok || cmd.deg_update;
		if (edge_ok) begin
			deg_waddr = dst_idx;
			deg_wdata = DEG_W'(deg_base + 1'b1);
		end else begin
			deg_waddr = y_idx;
			deg_wdata = run_deg_new;
		end
	end

	assign head_raddr = NODE_AW'(q_rdata - 1'b1);
	assign tail_raddr = cmd.load_accept ? NODE_AW'(from_node - 1'b1) : head_raddr;

	tsk_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_deg_ram (
		.clk   (clk),
		.we    (deg_we),
		.waddr (deg_waddr),
		.wdata (deg_wdata),
		.raddr (deg_raddr),
		.rdata (deg_rdata)
	);

	tsk_ram #(.WIDTH(EDGE_AW), .DEPTH(MAX_NODES)) u_head_ram (
		.clk   (clk),
		.we    (edge_ok && !list_vld_q[src_idx]),
		.waddr (src_idx),
		.wdata (edge_idx),
		.raddr (head_raddr),
		.rdata (head_rdata)
	);

	tsk_ram #(.WIDTH(EDGE_AW), .DEPTH(MAX_NODES)) u_tail_ram (
		.clk   (clk),
		.we    (edge_ok),
		.waddr (src_idx),
		.wdata (edge_idx),
		.raddr (tail_raddr),
		.rdata (tail_rdata)
	);

	tsk_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_tgt_ram (
		.clk   (clk),
		.we    (edge_ok),
		.waddr (edge_idx),
		.wdata (to_s2),
		.raddr (e_q),
		.rdata (tgt_rdata)
	);

	tsk_ram #(.WIDTH(EDGE_AW), .DEPTH(MAX_EDGES)) u_next_ram (
		.clk   (clk),
		.we    (edge_ok && list_vld_q[src_idx]),
		.waddr (tail_cur),
		.wdata (edge_idx),
		.raddr (e_q),
		.rdata (next_rdata)
	);

	tsk_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue_ram (
		.clk   (clk),
		.we    (push),
		.waddr (NODE_AW'(qt_q)),
		.wdata (push_node),
		.raddr (NODE_AW'(qh_q)),
		.rdata (q_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q   <= NODE_W'(MAX_NODES);
			edge_vld_s2    <= 1'b0;
			chk_vld_s1     <= 1'b0;
			seed_idx_q     <= '0;
			qh_q           <= '0;
			qt_q           <= '0;
			edge_total_q   <= '0;
			dropped_q      <= 1'b0;
			deg_vld_q      <= '0;
			list_vld_q     <= '0;
			fwd_deg_vld_q  <= 1'b0;
			fwd_tail_vld_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				node_count_q <= cfg_wr_data;
			end
			edge_vld_s2 <= cmd.load_accept;
			chk_vld_s1  <= cmd.seed_issue;
			if (cmd.run_start) begin
				seed_idx_q <= '0;
			end else if (cmd.seed_issue) begin
				seed_idx_q <= NODE_W'(seed_idx_q + 1'b1);
			end
			if (cmd.run_start) begin
				qt_q <= '0;
			end else if (push) begin
				qt_q <= QCNT_W'(qt_q + 1'b1);
			end
			if (cmd.run_start || cmd.emit_begin) begin
				qh_q <= '0;
			end else if (cmd.pop_issue || cmd.emit_next) begin
				qh_q <= QCNT_W'(qh_q + 1'b1);
			end
			if (cmd.clear_graph) begin
				edge_total_q   <= '0;
				dropped_q      <= 1'b0;
				deg_vld_q      <= '0;
				list_vld_q     <= '0;
				fwd_deg_vld_q  <= 1'b0;
				fwd_tail_vld_q <= 1'b0;
			end else begin
				if (edge_ok) begin
					deg_vld_q[dst_idx]  <= 1'b1;
					list_vld_q[src_idx] <= 1'b1;
					edge_total_q        <= EDGE_CW'(edge_total_q + 1'b1);
					fwd_deg_vld_q       <= 1'b1;
					fwd_tail_vld_q      <= 1'b1;
				end
				if (cmd.deg_update) begin
					deg_vld_q[y_idx] <= 1'b1;
				end
				if (edge_vld_s2 && edge_bad) begin
					dropped_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_accept) begin
			from_s2 <= from_node;
			to_s2   <= to_node;
		end
		if (edge_ok) begin
			fwd_deg_addr_q  <= dst_idx;
			fwd_deg_data_q  <= deg_wdata;
			fwd_tail_addr_q <= src_idx;
			fwd_tail_data_q <= edge_idx;
		end
		if (cmd.seed_issue) begin
			chk_addr_s1 <= NODE_AW'(seed_idx_q);
		end
		if (cmd.node_latch) begin
			x_q <= q_rdata;
		end
		if (cmd.list_latch) begin
			e_q   <= head_rdata;
			end_q <= tail_rdata;
		end else if (cmd.deg_update) begin
			e_q <= nxt_q;
		end
		if (cmd.edge_latch) begin
			y_q   <= tgt_rdata;
			nxt_q <= next_rdata;
		end
	end

	always_comb begin
		stat.seed_done     = (seed_idx_q == cnt);
		stat.queue_empty   = (qh_q == qt_q);
		stat.list_nonempty = list_vld_q[x_idx];
		stat.edge_end      = (e_q == end_q);
		stat.emit_zero     = (qt_q == '0);
		stat.emit_last     = stat.emit_zero || (QCNT_W'(qh_q + 1'b1) == qt_q);
	end

	assign node     = stat.emit_zero ? '0 : q_rdata;
	assign is_last  = stat.emit_last;
	assign complete = (NODE_W'(qt_q) == cnt);
	assign overflow = dropped_q;

	`ASSERT_ALWAYS(a_queue_order, clk, arst_n, qh_q <= qt_q)
	`ASSERT_NEVER(a_deg_write_clash, clk, arst_n, edge_vld_s2 && cmd.deg_update)
	`ASSERT_NEVER(a_push_clash, clk, arst_n, chk_vld_s1 && cmd.deg_update)
	`ASSERT_ALWAYS(a_clear_done, clk, arst_n, cmd.clear_graph |=> (edge_total_q == '0 && deg_vld_q == '0 && list_vld_q == '0 && !dropped_q))

endmodule

@@ design/topological_sort_kahn_core.sv @@
// Top level of the Kahn topological sort core: controller and datapath
//
// Channel   Handshake             Fields
// config    cfg_wr_en             cfg_wr_data (node_count), write only
// input     in_valid/in_ready     opcode, from_node, to_node
// output    out_valid/out_ready   node, is_last, complete, overflow
//
// An add item is accepted every cycle while idle; edge and in-degree memories
// are written in the cycle after acceptance. A run seeds the queue with nodes
// of zero in-degree, pops each, walks its edges lowering in-degrees, then emits the
// results (node 0 alone if none is ordered); out_ready low holds the current result.
// No clearing pass: valid bits reset at once and are cleared with the last result.
module topological_sort_kahn_core
	import tsk_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [NODE_W-1:0] cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              opcode,
	input  logic [NODE_W-1:0] from_node,
	input  logic [NODE_W-1:0] to_node,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [NODE_W-1:0] node,
	output logic              is_last,
	output logic              complete,
	output logic              overflow
);

	cmd_t  cmd;
	stat_t stat;

	tsk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tsk_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.from_node   (from_node),
		.to_node     (to_node),
		.cmd         (cmd),
		.stat        (stat),
		.node        (node),
		.is_last     (is_last),
		.complete    (complete),
		.overflow    (overflow)
	);

endmodule
